FILE: src/rrss_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rrss_pkg
// shared types and constants of the round robin scheduler with semaphores
// ----------------------------------------------------------------------------
package rrss_pkg;

	localparam int CMD_W    = 3;
	localparam int MILLIS_W = 16;
	localparam int SEM_ID_W = 4;
	localparam int TASK_W   = 4;
	localparam int RATE_W   = 10;
	localparam int SLEEP_W  = 17;
	localparam int PROD_W   = MILLIS_W + RATE_W;
	localparam int MS_PER_SEC = 1000;
	localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(100);

	typedef enum logic [CMD_W-1:0] {
		CMD_SCHED = 3'd0,
		CMD_SLEEP = 3'd1,
		CMD_SEM_P = 3'd2,
		CMD_SEM_V = 3'd3,
		CMD_SEM_INIT = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_TICK,
		ST_SEARCH,
		ST_SHIFT,
		ST_DONE
	} state_t;

	// control and status of the sleep divider, seen by the sequencer
	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} div_ctl_t;

endpackage

`default_nettype wire

FILE: src/rrss_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rrss_div
// reciprocal multiplier computing millis*rate/1000+1 for the sleep command
// ----------------------------------------------------------------------------
module rrss_div (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [rrss_pkg::MILLIS_W-1:0] millis,
	input  wire logic [rrss_pkg::RATE_W-1:0]   rate,
	output rrss_pkg::div_ctl_t             ctl,
	output logic [rrss_pkg::SLEEP_W-1:0]   sleep_val
);
	import rrss_pkg::*;

	// ceil(2^k/1000) with k = product width + 10 is exact for every product
	localparam int RECIP_SH = PROD_W + $clog2(MS_PER_SEC);
	localparam int RECIP_W  = 27;
	localparam logic [63:0] RECIP_FULL =
		((64'd1 << RECIP_SH) + 64'(MS_PER_SEC) - 64'd1) / 64'(MS_PER_SEC);
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);
	localparam int FULL_W = PROD_W + RECIP_W;

	logic [PROD_W-1:0]  prod_s1;
	logic [SLEEP_W-1:0] quo_s2;
	logic [FULL_W-1:0]  scaled;
	logic               busy_q;
	logic               done_q;

	assign scaled = FULL_W'(prod_s1) * FULL_W'(RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			busy_q <= start;
			done_q <= busy_q;
		end
	end

	// product first, scaled quotient registered in the next cycle
	always_ff @(posedge clk) begin
		if (start) begin
			prod_s1 <= PROD_W'(millis) * PROD_W'(rate);
		end
		if (busy_q) begin
			quo_s2 <= scaled[RECIP_SH +: SLEEP_W];
		end
	end

	assign ctl.start = start;
	assign ctl.busy  = busy_q;
	assign ctl.done  = done_q;
	assign sleep_val = quo_s2 + SLEEP_W'(1);

endmodule

`default_nettype wire

FILE: src/round_robin_scheduler_semaphores_core.sv
`default_nettype none
// sequence: a schedule scans the tasks, sleep first waits for the reciprocal divider,
//   V shifts its wait queue when it wakes a task; init and ignored commands skip the scan
// throughput: one item at a time; the sequencer's shared task scan sets the rate
// reset: all tasks ready and awake, task 0 running, every count 1, queues empty,
//   tick rate 100; queue entries are not cleared
// ----------------------------------------------------------------------------
// round_robin_scheduler_semaphores_core
// task scheduler with counting semaphores, sequenced over a shared task scan
// ----------------------------------------------------------------------------
module round_robin_scheduler_semaphores_core #(
	parameter int NUM_TASKS  = 4,
	parameter int WAIT_DEPTH = 8,
	parameter int NUM_SEMS   = 4
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [rrss_pkg::RATE_W-1:0]    cfg_wdata,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [rrss_pkg::CMD_W-1:0]     cmd,
	input  wire logic [rrss_pkg::MILLIS_W-1:0]  millis,
	input  wire logic [rrss_pkg::SEM_ID_W-1:0]  sem_id,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic [rrss_pkg::TASK_W-1:0]         current_task,
	output logic                                no_runnable,
	output logic                                caller_blocked,
	output logic                                woke,
	output logic [rrss_pkg::TASK_W-1:0]         woken_task,
	output logic signed [7:0]                   sem_value
);
	import rrss_pkg::*;

	localparam int TW  = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
	localparam int SW  = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
	localparam int QW  = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
	localparam int LW  = $clog2(WAIT_DEPTH + 1);
	localparam int CW  = ($clog2(NUM_TASKS + 1) > LW) ? $clog2(NUM_TASKS + 1) : LW;
	localparam int MW  = (NUM_SEMS * WAIT_DEPTH > 1) ? $clog2(NUM_SEMS * WAIT_DEPTH) : 1;

	logic [RATE_W-1:0]         rate_q;
	logic [NUM_TASKS-1:0]      ready_q;
	logic [SLEEP_W-1:0]        sleep_q [NUM_TASKS];
	logic [TW-1:0]             run_q;
	logic signed [7:0]         cnt_q [NUM_SEMS];
	logic [LW-1:0]             len_q [NUM_SEMS];
	logic [TW-1:0]             wmem [NUM_SEMS * WAIT_DEPTH];

	state_t state_q, state_d;
	logic [CW-1:0]   idx_q;      // task scan step / queue shift step
	logic [TW-1:0]   cand_q;
	logic            found_q;
	logic [SW-1:0]   sid_q;
	logic            sched_q;    // a schedule step follows (after the shift for V)
	logic            shift_q;
	logic [TW-1:0]   rd_q;       // registered memory read

	logic            res_valid_q;
	logic [TASK_W-1:0] r_task_q;
	logic            r_norun_q, r_blk_q, r_woke_q;
	logic [TASK_W-1:0] r_woken_q;
	logic signed [7:0] r_sval_q;

	div_ctl_t          dctl;
	logic [SLEEP_W-1:0] dval;
	logic              div_start;

	logic accept;
	logic sid_ok;
	logic [SW-1:0] sid_in;
	logic [TW-1:0] next_cand;
	logic [MW-1:0] rd_addr;
	logic [QW-1:0] sh_idx;
	logic [MW-1:0] base_addr;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE) || res_valid_q;
	assign sid_ok   = {1'b0, sem_id} < (SEM_ID_W + 1)'(NUM_SEMS);
	assign sid_in   = SW'(sem_id);
	assign div_start = accept && (cmd == CMD_SLEEP);
	assign next_cand = (cand_q == TW'(NUM_TASKS - 1)) ? '0 : cand_q + 1'b1;
	assign base_addr = MW'(sid_q) * MW'(WAIT_DEPTH);
	assign sh_idx    = QW'(idx_q);
	// entry at sh_idx+1 is fetched for the shift; entry 0 at the start
	assign rd_addr   = (state_q == ST_SHIFT) ? base_addr + MW'(sh_idx) + MW'(1)
	                                         : MW'(sid_in) * MW'(WAIT_DEPTH);

	rrss_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.millis    (millis),
		.rate      (rate_q),
		.ctl       (dctl),
		.sleep_val (dval)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= RATE_RESET;
		end else if (cfg_we) begin
			rate_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= wmem[rd_addr];
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (cmd)
						CMD_SCHED: state_d = ST_TICK;
						CMD_SLEEP: state_d = ST_DIV;
						CMD_SEM_P: state_d = sid_ok ? ST_TICK : ST_DONE;
						CMD_SEM_V: state_d = sid_ok ? ST_SHIFT : ST_DONE;
						default:   state_d = ST_DONE;
					endcase
				end
			end
			ST_DIV:    if (dctl.done) state_d = ST_TICK;
			ST_TICK:   state_d = sched_q ? ST_SEARCH : ST_DONE;
			ST_SEARCH: if (found_q || idx_q == CW'(NUM_TASKS)) state_d = ST_DONE;
			ST_SHIFT:  if (!shift_q || idx_q >= CW'(WAIT_DEPTH - 1)) state_d = ST_TICK;
			ST_DONE:   state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ready_q     <= '1;
			run_q       <= '0;
			res_valid_q <= 1'b0;
			for (int i = 0; i < NUM_TASKS; i++) sleep_q[i] <= '0;
			for (int s = 0; s < NUM_SEMS; s++) begin
				cnt_q[s] <= 8'sd1;
				len_q[s] <= '0;
			end
			idx_q <= '0; cand_q <= '0; found_q <= 1'b0; sid_q <= '0;
			sched_q <= 1'b0; shift_q <= 1'b0;
			r_task_q <= '0; r_norun_q <= 1'b0; r_blk_q <= 1'b0;
			r_woke_q <= 1'b0; r_woken_q <= '0; r_sval_q <= '0;
		end else begin
			state_q <= state_d;
			if (res_valid_q && !out_stall) res_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						idx_q <= '0; found_q <= 1'b0; sid_q <= sid_in;
						sched_q <= 1'b0; shift_q <= 1'b0;
						r_norun_q <= 1'b0; r_blk_q <= 1'b0; r_woke_q <= 1'b0;
						r_woken_q <= '0; r_sval_q <= '0;
						case (cmd)
							CMD_SCHED, CMD_SLEEP: sched_q <= 1'b1;
							CMD_SEM_P: if (sid_ok) begin
								if (cnt_q[sid_in] != -8'sd128) begin
									cnt_q[sid_in] <= cnt_q[sid_in] - 8'sd1;
									r_sval_q <= cnt_q[sid_in] - 8'sd1;
								end else begin
									r_sval_q <= cnt_q[sid_in];
								end
								if (cnt_q[sid_in] <= 8'sd0) begin
									sched_q <= 1'b1; r_blk_q <= 1'b1;
									ready_q[run_q] <= 1'b0;
									if (len_q[sid_in] < LW'(WAIT_DEPTH)) begin
										len_q[sid_in] <= len_q[sid_in] + 1'b1;
									end
								end
							end
							CMD_SEM_V: if (sid_ok) begin
								sched_q <= 1'b1;
								if (cnt_q[sid_in] != 8'sd127) begin
									cnt_q[sid_in] <= cnt_q[sid_in] + 8'sd1;
									r_sval_q <= cnt_q[sid_in] + 8'sd1;
								end else begin
									r_sval_q <= cnt_q[sid_in];
								end
								if (cnt_q[sid_in] < 8'sd0 && len_q[sid_in] != '0) begin
									shift_q <= 1'b1; r_woke_q <= 1'b1;
									len_q[sid_in] <= len_q[sid_in] - 1'b1;
								end
							end
							CMD_SEM_INIT: if (sid_ok) begin
								cnt_q[sid_in] <= 8'sd1;
								len_q[sid_in] <= '0;
								r_sval_q <= 8'sd1;
							end
							default: ;
						endcase
						if (cmd == CMD_SLEEP) sleep_q[run_q] <= '1;
					end
				end
				ST_DIV: if (dctl.done) sleep_q[run_q] <= dval;
				ST_TICK: begin
					// sleepers only tick when a schedule step follows
					if (sched_q) begin
						for (int i = 0; i < NUM_TASKS; i++)
							if (sleep_q[i] != '0) sleep_q[i] <= sleep_q[i] - 1'b1;
					end
					cand_q <= run_q;
					idx_q  <= '0;
				end
				ST_SEARCH: begin
					if (!found_q && idx_q != CW'(NUM_TASKS)) begin
						cand_q <= next_cand;
						idx_q  <= idx_q + 1'b1;
						if (ready_q[next_cand] && sleep_q[next_cand] == '0) begin
							found_q <= 1'b1;
							run_q   <= next_cand;
						end
					end
				end
				ST_SHIFT: begin
					if (shift_q) begin
						// first cycle: rd_q holds the head
						if (idx_q == '0) begin
							r_woken_q <= TASK_W'(rd_q);
							ready_q[rd_q] <= 1'b1;
						end
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_DONE: begin
					res_valid_q <= 1'b1;
					r_task_q    <= TASK_W'(run_q);
					r_norun_q   <= sched_q && !found_q;
				end
				default: ;
			endcase
		end
	end

	// queue memory: P enqueues at accept, V shifts one entry per cycle
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept && cmd == CMD_SEM_P && sid_ok
		    && cnt_q[sid_in] <= 8'sd0 && len_q[sid_in] < LW'(WAIT_DEPTH)) begin
			wmem[MW'(sid_in) * MW'(WAIT_DEPTH) + MW'(len_q[sid_in])] <= run_q;
		end else if (state_q == ST_SHIFT && shift_q && idx_q != '0) begin
			wmem[base_addr + MW'(idx_q) - MW'(1)] <= rd_q;
		end
	end

	assign out_valid      = res_valid_q;
	assign current_task   = r_task_q;
	assign no_runnable    = r_norun_q;
	assign caller_blocked = r_blk_q;
	assign woke           = r_woke_q;
	assign woken_task     = r_woken_q;
	assign sem_value      = r_sval_q;

	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> in_stall) else $error("accepting while busy");
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |=> out_valid) else $error("result not presented");
	a_woke_blk: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(woke && caller_blocked)) else $error("woke and blocked");
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=>
		(out_valid && $stable(current_task) && $stable(sem_value)))
		else $error("result changed while stalled");

endmodule

`default_nettype wire
